// ===== design/xavn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the XML attribute value normalizer.
// No dependencies; used by the interfaces, the core, the result buffer and the top level.

package xavn_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned MAX_RES = 3;

  localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
  localparam logic [ERR_W-1:0] ERR_QUOTE  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_LT     = 3'd2;
  localparam logic [ERR_W-1:0] ERR_CHAR   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_UPPERX = 3'd4;
  localparam logic [ERR_W-1:0] ERR_DIGIT  = 3'd5;
  localparam logic [ERR_W-1:0] ERR_EOI    = 3'd6;
  localparam logic [ERR_W-1:0] ERR_ENTITY = 3'd7;

  localparam logic [UNIT_W-1:0] CH_NUL    = 16'h0000;
  localparam logic [UNIT_W-1:0] CH_TAB    = 16'h0009;
  localparam logic [UNIT_W-1:0] CH_LF     = 16'h000A;
  localparam logic [UNIT_W-1:0] CH_CR     = 16'h000D;
  localparam logic [UNIT_W-1:0] CH_SPACE  = 16'h0020;
  localparam logic [UNIT_W-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [UNIT_W-1:0] CH_HASH   = 16'h0023;
  localparam logic [UNIT_W-1:0] CH_AMP    = 16'h0026;
  localparam logic [UNIT_W-1:0] CH_SQUOTE = 16'h0027;
  localparam logic [UNIT_W-1:0] CH_SEMI   = 16'h003B;
  localparam logic [UNIT_W-1:0] CH_LT     = 16'h003C;
  localparam logic [UNIT_W-1:0] CH_UPPERX = 16'h0058;
  localparam logic [UNIT_W-1:0] CH_LOWERX = 16'h0078;
  localparam logic [UNIT_W-1:0] UNIT_MAX  = 16'hFFFD;
  localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

  localparam logic [CP_W-1:0] CP_BMP_END = 21'h00FFFF;
  localparam logic [CP_W-1:0] CP_SUPP    = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SAT     = 21'h110000;

  localparam logic [CNT_W-1:0] CNT_SAT        = 8'hFF;
  localparam logic [CNT_W-1:0] MAX_ERRORS_RST = 8'hFF;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              valid;
    logic [ERR_W-1:0]  err;
    logic              done;
    logic              ok;
    logic              limit;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] r;
    logic [1:0]         cnt;
  } bundle_t;

endpackage

// ===== design/xavn_unit_if.sv =====
`timescale 1ns / 1ps
// Input channel: one UTF-16 code unit with its start and type marks per word.
// Depends on xavn_pkg.

interface xavn_unit_if;
  logic                          valid;
  logic                          ready;
  logic [xavn_pkg::UNIT_W-1:0]   code_unit;
  logic                          starts_value;
  logic                          is_cdata;

  modport source (output valid, code_unit, starts_value, is_cdata, input ready);
  modport sink   (input valid, code_unit, starts_value, is_cdata, output ready);
endinterface

// ===== design/xavn_result_if.sv =====
`timescale 1ns / 1ps
// Result channel: one normalized unit or status word per handshake.
// Depends on xavn_pkg.

interface xavn_result_if;
  logic                         valid;
  logic                         ready;
  logic [xavn_pkg::UNIT_W-1:0]  out_unit;
  logic                         unit_valid;
  logic [xavn_pkg::ERR_W-1:0]   error_code;
  logic                         limit_hit;
  logic                         value_done;
  logic                         value_ok;
  logic                         last;

  modport source (output valid, out_unit, unit_valid, error_code, limit_hit, value_done,
                  value_ok, last, input ready);
  modport sink   (input valid, out_unit, unit_valid, error_code, limit_hit, value_done,
                  value_ok, last, output ready);
endinterface

// ===== design/xavn_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel carrying the max_errors register.
// Depends on xavn_pkg.

interface xavn_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [xavn_pkg::CNT_W-1:0]  max_errors;

  modport source (output valid, max_errors, input ready);
  modport sink   (input valid, max_errors, output ready);
endinterface

// ===== design/xavn_core.sv =====
`timescale 1ns / 1ps
// Normalizer core: value state, reference decoder, error counter and the
// result bundle for the word being accepted. Depends on xavn_pkg.

module xavn_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [xavn_pkg::UNIT_W-1:0] code_unit_i,
  input  logic                        starts_value_i,
  input  logic                        is_cdata_i,
  input  logic                        cfg_we_i,
  input  logic [xavn_pkg::CNT_W-1:0]  cfg_data_i,
  output xavn_pkg::bundle_t           bundle_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_BODY, PH_AMP, PH_REF_START, PH_REF_DIGITS
  } phase_e;

  typedef struct packed {
    xavn_pkg::bundle_t b;
    logic              ws;
    logic              ne;
  } norm_t;

  phase_e                       phase_q, phase_d;
  logic                         dquote_q, dquote_d;
  logic                         cdata_q, cdata_d;
  logic                         ws_q, ws_d;
  logic                         ne_q, ne_d;
  logic                         hex_q, hex_d;
  logic [xavn_pkg::CP_W-1:0]    acc_q, acc_d;
  logic [xavn_pkg::CNT_W-1:0]   err_cnt_q, err_cnt_d;
  logic [xavn_pkg::CNT_W-1:0]   max_q;

  logic [xavn_pkg::UNIT_W-1:0]  u;
  logic [xavn_pkg::UNIT_W-1:0]  quote;
  logic [4:0]                   digit;
  logic                         digit_ok;
  logic [24:0]                  prod;
  logic [xavn_pkg::CP_W-1:0]    acc_next;
  logic [xavn_pkg::CNT_W-1:0]   run_cnt;
  xavn_pkg::bundle_t            b;
  norm_t                        nrm;

  function automatic xavn_pkg::res_t mk(logic [xavn_pkg::UNIT_W-1:0] unit, logic valid,
                                         logic [xavn_pkg::ERR_W-1:0] err, logic done,
                                         logic ok);
    xavn_pkg::res_t r;
    r.unit  = valid ? unit : '0;
    r.valid = valid;
    r.err   = err;
    r.done  = done;
    r.ok    = ok;
    r.limit = 1'b0;
    return r;
  endfunction

  function automatic xavn_pkg::bundle_t push(xavn_pkg::bundle_t bi, xavn_pkg::res_t r);
    xavn_pkg::bundle_t bo;
    bo = bi;
    if (bi.cnt < 2'(xavn_pkg::MAX_RES)) begin
      bo.r[bi.cnt] = r;
      bo.cnt       = bi.cnt + 2'd1;
    end
    return bo;
  endfunction

  function automatic logic is_space(logic [xavn_pkg::UNIT_W-1:0] c);
    return c == xavn_pkg::CH_SPACE || c == xavn_pkg::CH_TAB ||
           c == xavn_pkg::CH_LF || c == xavn_pkg::CH_CR;
  endfunction

  function automatic logic xml_unit(logic [xavn_pkg::UNIT_W-1:0] c);
    return c == xavn_pkg::CH_TAB || c == xavn_pkg::CH_LF || c == xavn_pkg::CH_CR ||
           (c >= xavn_pkg::CH_SPACE && c <= xavn_pkg::UNIT_MAX);
  endfunction

  function automatic logic xml_cp(logic [xavn_pkg::CP_W-1:0] c);
    logic [xavn_pkg::UNIT_W-1:0] lo;
    lo = c[xavn_pkg::UNIT_W-1:0];
    if (c <= xavn_pkg::CP_BMP_END) begin
      return xml_unit(lo) && !(lo >= xavn_pkg::HI_SURR && lo < 16'hE000);
    end
    return c <= xavn_pkg::CP_MAX;
  endfunction

  function automatic norm_t normalize(xavn_pkg::bundle_t bi, logic [xavn_pkg::UNIT_W-1:0] c,
                                      logic esc, logic cd, logic ws, logic ne);
    norm_t n;
    n.b  = bi;
    n.ws = ws;
    n.ne = ne;
    if (cd) begin
      if (!esc && (c == xavn_pkg::CH_TAB || c == xavn_pkg::CH_LF || c == xavn_pkg::CH_CR)) begin
        n.b  = push(n.b, mk(xavn_pkg::CH_SPACE, 1'b1, xavn_pkg::ERR_NONE, 1'b0, 1'b0));
        n.ne = 1'b0;
      end else if (!xml_unit(c)) begin
        n.b = push(n.b, mk('0, 1'b0, xavn_pkg::ERR_CHAR, 1'b0, 1'b0));
      end else begin
        n.b  = push(n.b, mk(c, 1'b1, xavn_pkg::ERR_NONE, 1'b0, 1'b0));
        n.ne = 1'b0;
      end
    end else if (ws) begin
      if (!is_space(c)) begin
        if (!xml_unit(c)) begin
          n.b = push(n.b, mk('0, 1'b0, xavn_pkg::ERR_CHAR, 1'b0, 1'b0));
        end else begin
          if (!ne) begin
            n.b = push(n.b, mk(xavn_pkg::CH_SPACE, 1'b1, xavn_pkg::ERR_NONE, 1'b0, 1'b0));
          end
          n.ws = 1'b0;
          n.b  = push(n.b, mk(c, 1'b1, xavn_pkg::ERR_NONE, 1'b0, 1'b0));
          n.ne = 1'b0;
        end
      end
    end else if (is_space(c)) begin
      n.ws = 1'b1;
    end else if (!xml_unit(c)) begin
      n.b = push(n.b, mk('0, 1'b0, xavn_pkg::ERR_CHAR, 1'b0, 1'b0));
    end else begin
      n.b  = push(n.b, mk(c, 1'b1, xavn_pkg::ERR_NONE, 1'b0, 1'b0));
      n.ne = 1'b0;
    end
    return n;
  endfunction

  function automatic norm_t finish(xavn_pkg::bundle_t bi, logic [xavn_pkg::CP_W-1:0] c,
                                   logic cd, logic ws, logic ne);
    norm_t                        n;
    logic [xavn_pkg::CP_W-1:0]    v;
    logic [xavn_pkg::UNIT_W-1:0]  hi;
    logic [xavn_pkg::UNIT_W-1:0]  lo;
    v  = c - xavn_pkg::CP_SUPP;
    hi = xavn_pkg::HI_SURR | {6'b0, v[19:10]};
    lo = xavn_pkg::LO_SURR | {6'b0, v[9:0]};
    n.b  = bi;
    n.ws = ws;
    n.ne = ne;
    if (!xml_cp(c)) begin
      n.b = push(bi, mk('0, 1'b0, xavn_pkg::ERR_CHAR, 1'b0, 1'b0));
    end else if (c > xavn_pkg::CP_BMP_END) begin
      n = normalize(bi, hi, 1'b1, cd, ws, ne);
      n = normalize(n.b, lo, 1'b1, cd, n.ws, n.ne);
    end else begin
      n = normalize(bi, c[xavn_pkg::UNIT_W-1:0], 1'b1, cd, ws, ne);
    end
    return n;
  endfunction

  assign u     = code_unit_i;
  assign quote = dquote_q ? xavn_pkg::CH_DQUOTE : xavn_pkg::CH_SQUOTE;

  always_comb begin
    digit_ok = 1'b1;
    digit    = {1'b0, u[3:0]};
    if (u >= 16'h0030 && u <= 16'h0039) begin
      digit = {1'b0, u[3:0]};
    end else if ((u >= 16'h0061 && u <= 16'h0066) || (u >= 16'h0041 && u <= 16'h0046)) begin
      digit = {1'b0, u[3:0]} + 5'd9;
    end else begin
      digit_ok = 1'b0;
    end
    if (!hex_q && digit > 5'd9) begin
      digit_ok = 1'b0;
    end
    prod = hex_q ? {acc_q, 4'b0} : ({1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0});
    prod = prod + 25'(digit);
    acc_next = (acc_q > xavn_pkg::CP_MAX || prod > 25'(xavn_pkg::CP_MAX)) ?
               xavn_pkg::CP_SAT : prod[xavn_pkg::CP_W-1:0];
  end

  always_comb begin
    phase_d  = phase_q;
    dquote_d = dquote_q;
    cdata_d  = cdata_q;
    ws_d     = ws_q;
    ne_d     = ne_q;
    hex_d    = hex_q;
    acc_d    = acc_q;
    b        = '0;
    nrm      = '0;

    if (starts_value_i) begin
      if (u == xavn_pkg::CH_DQUOTE || u == xavn_pkg::CH_SQUOTE) begin
        phase_d  = PH_BODY;
        dquote_d = (u == xavn_pkg::CH_DQUOTE);
        cdata_d  = is_cdata_i;
        ws_d     = 1'b1;
        ne_d     = 1'b1;
        hex_d    = 1'b0;
        acc_d    = '0;
      end else begin
        phase_d = PH_IDLE;
        b = push(b, mk('0, 1'b0, xavn_pkg::ERR_QUOTE, 1'b1, 1'b0));
      end
    end else if (phase_q == PH_IDLE) begin
      phase_d = PH_IDLE;
    end else if (u == xavn_pkg::CH_NUL) begin
      phase_d = PH_IDLE;
      b = push(b, mk('0, 1'b0, xavn_pkg::ERR_EOI, 1'b1, 1'b0));
    end else begin
      case (phase_q)
        PH_BODY: begin
          if (u == xavn_pkg::CH_LT) begin
            b = push(b, mk('0, 1'b0, xavn_pkg::ERR_LT, 1'b0, 1'b0));
          end
          if (u == quote) begin
            phase_d = PH_IDLE;
            b = push(b, mk('0, 1'b0, xavn_pkg::ERR_NONE, 1'b1, 1'b1));
          end else if (u == xavn_pkg::CH_AMP) begin
            phase_d = PH_AMP;
          end else begin
            nrm  = normalize(b, u, 1'b0, cdata_q, ws_q, ne_q);
            b    = nrm.b;
            ws_d = nrm.ws;
            ne_d = nrm.ne;
          end
        end
        PH_AMP: begin
          if (u == xavn_pkg::CH_HASH) begin
            phase_d = PH_REF_START;
            hex_d   = 1'b0;
            acc_d   = '0;
          end else begin
            b = push(b, mk('0, 1'b0, xavn_pkg::ERR_ENTITY, 1'b0, 1'b0));
            if (u == quote) begin
              phase_d = PH_IDLE;
              b = push(b, mk('0, 1'b0, xavn_pkg::ERR_NONE, 1'b1, 1'b1));
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_REF_START, PH_REF_DIGITS: begin
          phase_d = PH_REF_DIGITS;
          if (phase_q == PH_REF_START && u == xavn_pkg::CH_LOWERX) begin
            hex_d = 1'b1;
          end else if (phase_q == PH_REF_START && u == xavn_pkg::CH_UPPERX) begin
            hex_d = 1'b1;
            b = push(b, mk('0, 1'b0, xavn_pkg::ERR_UPPERX, 1'b0, 1'b0));
          end else if (u == xavn_pkg::CH_SEMI) begin
            phase_d = PH_BODY;
            nrm  = finish(b, acc_q, cdata_q, ws_q, ne_q);
            b    = nrm.b;
            ws_d = nrm.ws;
            ne_d = nrm.ne;
          end else if (!digit_ok) begin
            phase_d = PH_BODY;
            b = push(b, mk('0, 1'b0, xavn_pkg::ERR_DIGIT, 1'b0, 1'b0));
          end else begin
            acc_d = acc_next;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    run_cnt = err_cnt_q;
    for (int k = 0; k < xavn_pkg::MAX_RES; k++) begin
      if (2'(k) < b.cnt && b.r[k].err != xavn_pkg::ERR_NONE && run_cnt != xavn_pkg::CNT_SAT) begin
        run_cnt = run_cnt + 8'd1;
      end
      b.r[k].limit = (run_cnt >= max_q);
    end
    err_cnt_d = run_cnt;
  end

  assign bundle_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      dquote_q  <= 1'b0;
      cdata_q   <= 1'b0;
      ws_q      <= 1'b0;
      ne_q      <= 1'b1;
      hex_q     <= 1'b0;
      acc_q     <= '0;
      err_cnt_q <= '0;
      max_q     <= xavn_pkg::MAX_ERRORS_RST;
    end else begin
      if (accept_i) begin
        phase_q   <= phase_d;
        dquote_q  <= dquote_d;
        cdata_q   <= cdata_d;
        ws_q      <= ws_d;
        ne_q      <= ne_d;
        hex_q     <= hex_d;
        acc_q     <= acc_d;
        err_cnt_q <= err_cnt_d;
      end
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== design/xavn_outbuf.sv =====
`timescale 1ns / 1ps
// Result register: holds the bundle of one accepted word and hands out its
// results one per handshake. Depends on xavn_pkg.

module xavn_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  xavn_pkg::bundle_t    bundle_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output xavn_pkg::res_t       res_o,
  output logic                 last_o,
  output logic                 in_ready_o
);

  xavn_pkg::res_t [xavn_pkg::MAX_RES-1:0] res_q;
  logic [1:0]                             cnt_q;
  logic [1:0]                             idx_q;
  logic                                   out_fire;
  logic                                   at_last;

  assign out_valid_o = cnt_q != 2'd0;
  assign out_fire    = out_valid_o && out_ready_i;
  assign at_last     = idx_q == (cnt_q - 2'd1);
  assign in_ready_o  = !out_valid_o || (out_fire && at_last);
  assign res_o       = res_q[idx_q];
  assign last_o      = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
      idx_q <= '0;
    end else if (out_fire) begin
      if (at_last) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.r;
    end
  end

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && bundle_i.cnt != 2'd0) |=> out_valid_o)
    else $error("loaded bundle not presented");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < cnt_q))
    else $error("result index beyond bundle");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(idx_q) && $stable(cnt_q)))
    else $error("bundle moved while stalled");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !at_last) |=> (idx_q == $past(idx_q) + 2'd1))
    else $error("result index did not advance");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> in_ready_o)
    else $error("word loaded over pending results");

endmodule

// ===== design/xml_attr_value_normalizer_top.sv =====
`timescale 1ns / 1ps
// Top level of the XML attribute value normalizer: core and result buffer.
// Depends on xavn_pkg, the channel interfaces, xavn_core and xavn_outbuf.
//
//   channel   | dir | word
//   unit_i    | in  | code_unit, starts_value, is_cdata
//   result_o  | out | out_unit, unit_valid, error_code, limit_hit, value_done, value_ok, last
//   cfg_i     | in  | max_errors
//
// While result_o is ready, a word that gives zero or one result is taken every cycle; a word
// that gives k results holds the input while the result buffer drains one per cycle.
// Results appear in the cycle after the word is taken.
// Reset clears all value state and sets max_errors to 255; no clearing pass.
// A stall on result_o holds the buffer and, once it is full, the input.

module xml_attr_value_normalizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  xavn_unit_if.sink     unit_i,
  xavn_result_if.source result_o,
  xavn_cfg_if.sink      cfg_i
);

  logic              in_ready;
  logic              accept;
  xavn_pkg::bundle_t bundle;
  xavn_pkg::res_t    res;
  logic              res_last;

  assign accept       = unit_i.valid && in_ready;
  assign unit_i.ready = in_ready;
  assign cfg_i.ready  = 1'b1;

  xavn_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .code_unit_i    (unit_i.code_unit),
    .starts_value_i (unit_i.starts_value),
    .is_cdata_i     (unit_i.is_cdata),
    .cfg_we_i       (cfg_i.valid),
    .cfg_data_i     (cfg_i.max_errors),
    .bundle_o       (bundle)
  );

  xavn_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .bundle_i    (bundle),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .res_o       (res),
    .last_o      (res_last),
    .in_ready_o  (in_ready)
  );

  assign result_o.out_unit   = res.unit;
  assign result_o.unit_valid = res.valid;
  assign result_o.error_code = res.err;
  assign result_o.limit_hit  = res.limit;
  assign result_o.value_done = res.done;
  assign result_o.value_ok   = res.ok;
  assign result_o.last       = res_last;

endmodule

// ===== tb/sv/xavn_checker.sv =====
`timescale 1ns / 1ps
// Checker of the XML attribute value normalizer: watches the unit, result and config channels,
// predicts each result word from the accepted unit words and compares the two in order.
// Depends on xavn_pkg and the channel interfaces.

module xavn_checker
  import xavn_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  xavn_unit_if   unit_mon,
  xavn_result_if result_mon,
  xavn_cfg_if    cfg_mon,
  output int     fail_count_o,
  output int     open_count_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_BODY, ST_AMP, ST_REF_START, ST_REF_DIGITS} scan_e;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              valid;
    logic [ERR_W-1:0]  err;
    logic              limit;
    logic              done;
    logic              ok;
    logic              last;
  } result_word_t;

  result_word_t     expected_words[$];
  result_word_t     step_words[$];
  scan_e            scan_q;
  logic             dquote_q;
  logic             cdata_q;
  logic             in_space_q;
  logic             none_out_q;
  logic             ref_hex_q;
  logic [CP_W-1:0]  ref_acc_q;
  logic [CNT_W-1:0] err_count_q;
  logic [CNT_W-1:0] max_errors_q;
  int               fails = 0;

  function automatic logic is_blank(logic [UNIT_W-1:0] u);
    return u == CH_SPACE || u == CH_TAB || u == CH_LF || u == CH_CR;
  endfunction

  function automatic logic legal_unit(logic [UNIT_W-1:0] u);
    return u == CH_TAB || u == CH_LF || u == CH_CR || (u >= CH_SPACE && u <= UNIT_MAX);
  endfunction

  function automatic logic legal_point(logic [CP_W-1:0] c);
    return c == CP_W'(CH_TAB) || c == CP_W'(CH_LF) || c == CP_W'(CH_CR) ||
           (c >= CP_W'(CH_SPACE) && c <= 21'h00D7FF) ||
           (c >= 21'h00E000 && c <= CP_W'(UNIT_MAX)) || (c >= CP_SUPP && c <= CP_MAX);
  endfunction

  function automatic string show(result_word_t w);
    return $sformatf("unit=%h valid=%b err=%0d limit=%b done=%b ok=%b last=%b",
                     w.unit, w.valid, w.err, w.limit, w.done, w.ok, w.last);
  endfunction

  task automatic post_word(input logic [UNIT_W-1:0] u, input logic v, input logic [ERR_W-1:0] e,
                           input logic d, input logic k);
    result_word_t w;
    if (step_words.size() >= MAX_RES) return;
    if (e != ERR_NONE && err_count_q != CNT_SAT) err_count_q++;
    w.unit  = v ? u : CH_NUL;
    w.valid = v;
    w.err   = e;
    w.limit = err_count_q >= max_errors_q;
    w.done  = d;
    w.ok    = k;
    w.last  = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic emit_unit(input logic [UNIT_W-1:0] u);
    none_out_q = 1'b0;
    post_word(u, 1'b1, ERR_NONE, 1'b0, 1'b0);
  endtask

  task automatic put_unit(input logic [UNIT_W-1:0] u, input logic escaped);
    if (cdata_q) begin
      if (!escaped && (u == CH_TAB || u == CH_LF || u == CH_CR)) emit_unit(CH_SPACE);
      else if (!legal_unit(u)) post_word(CH_NUL, 1'b0, ERR_CHAR, 1'b0, 1'b0);
      else emit_unit(u);
    end else if (is_blank(u)) begin
      in_space_q = 1'b1;
    end else if (!legal_unit(u)) begin
      post_word(CH_NUL, 1'b0, ERR_CHAR, 1'b0, 1'b0);
    end else begin
      if (in_space_q && !none_out_q) emit_unit(CH_SPACE);
      in_space_q = 1'b0;
      emit_unit(u);
    end
  endtask

  task automatic close_reference();
    logic [CP_W-1:0]   v;
    logic [UNIT_W-1:0] hi;
    logic [UNIT_W-1:0] lo;
    scan_q = ST_BODY;
    if (!legal_point(ref_acc_q)) begin
      post_word(CH_NUL, 1'b0, ERR_CHAR, 1'b0, 1'b0);
    end else if (ref_acc_q > CP_BMP_END) begin
      v  = ref_acc_q - CP_SUPP;
      hi = HI_SURR + {6'b0, v[19:10]};
      lo = LO_SURR + {6'b0, v[9:0]};
      put_unit(hi, 1'b1);
      put_unit(lo, 1'b1);
    end else begin
      put_unit(ref_acc_q[UNIT_W-1:0], 1'b1);
    end
  endtask

  task automatic take_digit(input logic [UNIT_W-1:0] u);
    int unsigned d;
    int unsigned radix;
    int unsigned acc;
    radix = ref_hex_q ? 16 : 10;
    if (u >= 16'h0030 && u <= 16'h0039) d = 32'(u - 16'h0030);
    else if (u >= 16'h0061 && u <= 16'h0066) d = 10 + 32'(u - 16'h0061);
    else if (u >= 16'h0041 && u <= 16'h0046) d = 10 + 32'(u - 16'h0041);
    else d = 99;
    if (d >= radix) begin
      post_word(CH_NUL, 1'b0, ERR_DIGIT, 1'b0, 1'b0);
      scan_q = ST_BODY;
    end else begin
      acc = 32'(ref_acc_q);
      if (acc <= CP_MAX) acc = acc * radix + d;
      if (acc > CP_MAX) acc = CP_SAT;
      ref_acc_q = acc[CP_W-1:0];
    end
  endtask

  task automatic normalize_step(input logic [UNIT_W-1:0] u, input logic sv, input logic cd);
    logic [UNIT_W-1:0] quote;
    result_word_t      w;
    int                i;
    step_words.delete();
    quote = dquote_q ? CH_DQUOTE : CH_SQUOTE;
    if (sv) begin
      if (u == CH_DQUOTE || u == CH_SQUOTE) begin
        scan_q     = ST_BODY;
        dquote_q   = u == CH_DQUOTE;
        cdata_q    = cd;
        in_space_q = 1'b1;
        none_out_q = 1'b1;
        ref_hex_q  = 1'b0;
        ref_acc_q  = '0;
      end else begin
        scan_q = ST_IDLE;
        post_word(CH_NUL, 1'b0, ERR_QUOTE, 1'b1, 1'b0);
      end
    end else if (scan_q != ST_IDLE) begin
      if (u == CH_NUL) begin
        scan_q = ST_IDLE;
        post_word(CH_NUL, 1'b0, ERR_EOI, 1'b1, 1'b0);
      end else begin
        case (scan_q)
          ST_BODY: begin
            if (u == CH_LT) post_word(CH_NUL, 1'b0, ERR_LT, 1'b0, 1'b0);
            if (u == quote) begin
              scan_q = ST_IDLE;
              post_word(CH_NUL, 1'b0, ERR_NONE, 1'b1, 1'b1);
            end else if (u == CH_AMP) begin
              scan_q = ST_AMP;
            end else begin
              put_unit(u, 1'b0);
            end
          end
          ST_AMP: begin
            if (u == CH_HASH) begin
              scan_q    = ST_REF_START;
              ref_hex_q = 1'b0;
              ref_acc_q = '0;
            end else begin
              post_word(CH_NUL, 1'b0, ERR_ENTITY, 1'b0, 1'b0);
              if (u == quote) begin
                scan_q = ST_IDLE;
                post_word(CH_NUL, 1'b0, ERR_NONE, 1'b1, 1'b1);
              end else begin
                scan_q = ST_BODY;
              end
            end
          end
          ST_REF_START: begin
            scan_q = ST_REF_DIGITS;
            if (u == CH_LOWERX) begin
              ref_hex_q = 1'b1;
            end else if (u == CH_UPPERX) begin
              ref_hex_q = 1'b1;
              post_word(CH_NUL, 1'b0, ERR_UPPERX, 1'b0, 1'b0);
            end else if (u == CH_SEMI) begin
              close_reference();
            end else begin
              take_digit(u);
            end
          end
          default: begin
            if (u == CH_SEMI) close_reference();
            else take_digit(u);
          end
        endcase
      end
    end
    for (i = 0; i < step_words.size(); i++) begin
      w      = step_words[i];
      w.last = i == step_words.size() - 1;
      expected_words.push_back(w);
    end
  endtask

  task automatic compare_word();
    result_word_t got;
    result_word_t want;
    got.unit  = result_mon.out_unit;
    got.valid = result_mon.unit_valid;
    got.err   = result_mon.error_code;
    got.limit = result_mon.limit_hit;
    got.done  = result_mon.value_done;
    got.ok    = result_mon.value_ok;
    got.last  = result_mon.last;
    if (expected_words.size() == 0) begin
      fails++;
      if (fails <= 10) $display("%0t: result word with nothing expected: %s", $time, show(got));
    end else begin
      want = expected_words.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) begin
          $display("%0t: result word mismatch: expected %s, got %s", $time, show(want), show(got));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q       = ST_IDLE;
      dquote_q     = 1'b0;
      cdata_q      = 1'b0;
      in_space_q   = 1'b0;
      none_out_q   = 1'b1;
      ref_hex_q    = 1'b0;
      ref_acc_q    = '0;
      err_count_q  = '0;
      max_errors_q = MAX_ERRORS_RST;
      expected_words.delete();
      fail_count_o <= 0;
      open_count_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) max_errors_q = cfg_mon.max_errors;
      if (unit_mon.valid && unit_mon.ready) begin
        normalize_step(unit_mon.code_unit, unit_mon.starts_value, unit_mon.is_cdata);
      end
      if (result_mon.valid && result_mon.ready) compare_word();
      fail_count_o <= fails;
      open_count_o <= expected_words.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the normalizer testbench: clock, reset, directed and random unit words, random
// result stalls and max_errors writes between phases. Depends on xavn_pkg, the interfaces,
// xml_attr_value_normalizer_top and xavn_checker.

module testbench;
  import xavn_pkg::*;

  localparam int LIMIT_CYCLES = 100000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  int               cycle_count = 0;
  int               send_idle = 0;
  int               recv_stall = 0;
  int               words_sent = 0;
  int               fail_count;
  int               open_count;
  int               p;
  int               idle_plan[4] = '{0, 47, 0, 26};
  int               stall_plan[4] = '{0, 0, 47, 26};
  logic [CNT_W-1:0] cfg_plan[4];

  xavn_unit_if   unit_bus();
  xavn_result_if result_bus();
  xavn_cfg_if    cfg_bus();

  xml_attr_value_normalizer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .unit_i  (unit_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  xavn_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .unit_mon    (unit_bus),
    .result_mon  (result_bus),
    .cfg_mon     (cfg_bus),
    .fail_count_o(fail_count),
    .open_count_o(open_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[xml_attr_value_normalizer_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_bus.ready <= $urandom_range(99) >= recv_stall;
  end

  task automatic feed_unit(input logic [UNIT_W-1:0] u, input logic sv, input logic cd);
    while ($urandom_range(99) < send_idle) begin
      unit_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    unit_bus.valid        <= 1'b1;
    unit_bus.code_unit    <= u;
    unit_bus.starts_value <= sv;
    unit_bus.is_cdata     <= cd;
    do @(posedge clk_i); while (!unit_bus.ready);
    words_sent++;
  endtask

  task automatic feed(input logic [UNIT_W-1:0] u);
    feed_unit(u, 1'b0, 1'b0);
  endtask

  task automatic write_max_errors(input logic [CNT_W-1:0] v);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.max_errors <= v;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    unit_bus.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (open_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic feed_reference();
    int unsigned       cp;
    int unsigned       dv;
    int                sel;
    logic              hex;
    logic [UNIT_W-1:0] digs[$];
    sel = $urandom_range(99);
    if (sel < 30) cp = $urandom_range(32, 127);
    else if (sel < 55) cp = $urandom_range(128, 32'hFFFF);
    else if (sel < 85) cp = $urandom_range(32'h10000, 32'h10FFFF);
    else if (sel < 92) cp = $urandom_range(0, 31);
    else cp = $urandom_range(32'h110000, 32'hFFFFFF);
    hex = 1'($urandom_range(1));
    feed(CH_AMP);
    feed(CH_HASH);
    if (hex) feed($urandom_range(9) == 0 ? CH_UPPERX : CH_LOWERX);
    if (cp != 0 || $urandom_range(1)) begin
      do begin
        dv = hex ? cp % 16 : cp % 10;
        if (dv < 10) digs.push_front(16'(32'h0030 + dv));
        else if ($urandom_range(1)) digs.push_front(16'(32'h0061 + dv - 10));
        else digs.push_front(16'(32'h0041 + dv - 10));
        cp = hex ? cp / 16 : cp / 10;
      end while (cp != 0);
      if ($urandom_range(19) == 0) digs[$urandom_range(digs.size() - 1)] = 16'h0067;
    end
    foreach (digs[i]) feed(digs[i]);
    feed(CH_SEMI);
  endtask

  task automatic random_value();
    logic [UNIT_W-1:0] q;
    logic [UNIT_W-1:0] c;
    int                kind;
    int                ending;
    q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
    feed_unit(q, 1'b1, 1'($urandom_range(1)));
    repeat ($urandom_range(8)) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        do c = 16'($urandom_range(16'h0021, 16'h007E)); while (c == q || c == CH_AMP);
        feed(c);
      end else if (kind < 55) begin
        case ($urandom_range(3))
          0:       feed(CH_SPACE);
          1:       feed(CH_TAB);
          2:       feed(CH_LF);
          default: feed(CH_CR);
        endcase
      end else if (kind < 75) begin
        feed_reference();
      end else if (kind < 82) begin
        feed(16'($urandom_range(16'h0080, UNIT_MAX)));
      end else if (kind < 88) begin
        feed(16'($urandom()));
      end else if (kind < 92) begin
        feed(CH_LT);
      end else if (kind < 96) begin
        feed(CH_AMP);
        feed(16'($urandom_range(16'h0021, 16'h007E)));
      end else begin
        feed(16'($urandom_range(1) ? $urandom_range(1, 31) :
                                     $urandom_range(16'hFFFE, 16'hFFFF)));
      end
    end
    ending = $urandom_range(99);
    if (ending < 90) begin
      if (ending < 80) feed(q);
      else if (ending < 85) feed(CH_NUL);
      else feed_unit(16'($urandom_range(16'h0028, 16'hFFFF)), 1'b1, 1'($urandom_range(1)));
      if ($urandom_range(9) == 0) begin
        feed_unit(16'($urandom()), 1'b0, 1'($urandom_range(1)));
        words_sent--;
      end
    end
  endtask

  initial begin
    unit_bus.valid        = 1'b0;
    unit_bus.code_unit    = '0;
    unit_bus.starts_value = 1'b0;
    unit_bus.is_cdata     = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.max_errors    = '0;
    cfg_plan = '{8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'($urandom_range(1, 255))};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_max_errors(8'd3);
    feed(16'hFFFF);
    feed_unit(CH_UPPERX, 1'b1, 1'b0);
    feed_unit(CH_DQUOTE, 1'b1, 1'b1);
    feed(CH_TAB);
    feed(CH_LT);
    feed(16'hFFFF);
    feed(CH_AMP);
    feed(CH_HASH);
    feed(CH_UPPERX);
    feed(16'h0041);
    feed(CH_SEMI);
    feed(CH_DQUOTE);
    feed_unit(CH_SQUOTE, 1'b1, 1'b0);
    feed(CH_SPACE);
    feed(HI_SURR);
    feed(CH_LF);
    feed(CH_AMP);
    feed(CH_HASH);
    feed(CH_LOWERX);
    feed(16'h0031);
    repeat (4) feed(16'h0030);
    feed(CH_SEMI);
    feed(CH_AMP);
    feed(CH_SQUOTE);
    feed_unit(CH_DQUOTE, 1'b1, 1'b0);
    feed_unit(CH_DQUOTE, 1'b1, 1'b0);
    feed(CH_AMP);
    feed(CH_HASH);
    feed(CH_SEMI);
    feed(CH_NUL);
    drain();

    for (p = 0; p < 4; p++) begin
      write_max_errors(cfg_plan[p]);
      send_idle  = idle_plan[p];
      recv_stall = stall_plan[p];
      words_sent = 0;
      while (words_sent < 40) random_value();
      drain();
    end

    if (fail_count == 0 && open_count == 0) begin
      $display("[xml_attr_value_normalizer_top] OK");
    end else begin
      $display("[xml_attr_value_normalizer_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/xavn_pkg.sv
design/xavn_unit_if.sv
design/xavn_result_if.sv
design/xavn_cfg_if.sv
design/xavn_core.sv
design/xavn_outbuf.sv
design/xml_attr_value_normalizer_top.sv
tb/sv/xavn_checker.sv
tb/sv/testbench.sv
